// ===== src/byte_array_list_engine_defines.svh =====
// Assertion macros used by the checker file
`ifndef BYTE_ARRAY_LIST_ENGINE_DEFINES_SVH
`define BYTE_ARRAY_LIST_ENGINE_DEFINES_SVH

// cond must never hold outside reset
`define BALE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// same-cycle implication
`define BALE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BALE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/bale_pkg.sv =====
// Shared constants, types and command codes of the byte list engine
package bale_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int CMD_W = 3;
	localparam int POS_W = 6;
	localparam int EXT_W = (POS_W > CNT_W) ? POS_W : CNT_W;

	localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_ASC   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INS_DESC  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REM_FIRST = 3'd4;
	localparam logic [CMD_W-1:0] CMD_REM_ALL   = 3'd5;
	localparam logic [CMD_W-1:0] CMD_REM_AT    = 3'd6;

	typedef logic signed [7:0] byte_t;

	// broadcast from the controller to every cell of the chain
	typedef struct packed {
		logic             run;
		logic             wr;
		logic [CNT_W-1:0] step;
		logic [CNT_W-1:0] fill;
	} chain_ctrl_t;

endpackage

// ===== src/byte_array_list_engine.sv =====
// Byte list engine top level: controller plus a chain of DEPTH storage cells.
// A request is taken when start is high and busy is low. The list makes one full
// pass through the 64-cell shift chain past the head unit, plus a flush step that
// pushes in a pending element on an append or insert, so busy stays high through
// the pass and its result is shown in the first cycle with busy low. Requests that
// fail up front (insert into a full list, remove-at beyond the count, unused
// command code) leave the list alone and answer in the next cycle without raising busy.
// Each result is shown for a single cycle with done high and must be taken then;
// the receiver cannot stall. A new request may be issued in the cycle done is high.
module byte_array_list_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [bale_pkg::CMD_W-1:0]  command,
	input  bale_pkg::byte_t             value,
	input  logic [bale_pkg::POS_W-1:0]  position,
	output logic                        done,
	output logic                        ok,
	output logic [bale_pkg::POS_W-1:0]  found_index,
	output logic [bale_pkg::CNT_W-1:0]  count
);
	import bale_pkg::*;

	chain_ctrl_t  chain;
	byte_t        tail;
	byte_t        cell_data [DEPTH];

	bale_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.command     (command),
		.value       (value),
		.position    (position),
		.head        (cell_data[0]),
		.busy        (busy),
		.done        (done),
		.ok          (ok),
		.found_index (found_index),
		.count       (count),
		.chain       (chain),
		.tail        (tail)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == DEPTH - 1) begin : g_last
			bale_cell u_cell (
				.clk   (clk),
				.ctl   (chain),
				.idx   (IDX_W'(i)),
				.right (tail),
				.data  (cell_data[i])
			);
		end else begin : g_mid
			bale_cell u_cell (
				.clk   (clk),
				.ctl   (chain),
				.idx   (IDX_W'(i)),
				.right (cell_data[i+1]),
				.data  (cell_data[i])
			);
		end
	end

endmodule

// ===== src/bale_cell.sv =====
// One storage cell of the shifting list chain
module bale_cell (
	input  logic                        clk,
	input  bale_pkg::chain_ctrl_t       ctl,
	input  logic [bale_pkg::IDX_W-1:0]  idx,
	input  bale_pkg::byte_t             right,
	output bale_pkg::byte_t             data
);
	import bale_pkg::*;

	logic   rd_shift;
	logic   wr_shift;
	byte_t  data_q;

	// unread part drains towards cell 0; written part fills in from the tail
	always_comb begin
		rd_shift = ctl.run && ((SUM_W'(idx) + SUM_W'(ctl.step)) < SUM_W'(DEPTH - 1));
		wr_shift = ctl.run && ctl.wr && ((SUM_W'(idx) + SUM_W'(ctl.fill)) >= SUM_W'(DEPTH - 1));
	end

	always_ff @(posedge clk) begin
		if (rd_shift || wr_shift) begin
			data_q <= right;
		end
	end

	assign data = data_q;

endmodule

// ===== src/bale_ctrl.sv =====
// Head unit and sequencer: streams the list past the head and decides what goes back in
module bale_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bale_pkg::CMD_W-1:0]  command,
	input  bale_pkg::byte_t             value,
	input  logic [bale_pkg::POS_W-1:0]  position,
	input  bale_pkg::byte_t             head,
	output logic                        busy,
	output logic                        done,
	output logic                        ok,
	output logic [bale_pkg::POS_W-1:0]  found_index,
	output logic [bale_pkg::CNT_W-1:0]  count,
	output bale_pkg::chain_ctrl_t       chain,
	output bale_pkg::byte_t             tail
);
	import bale_pkg::*;

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t             state_q;
	logic [CMD_W-1:0]   cmd_q;
	byte_t              val_q;
	logic [POS_W-1:0]   pos_q;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   step_q;
	logic [CNT_W-1:0]   fill_q;
	byte_t              carry_q;
	logic               ins_q;
	logic               hit_q;
	logic [IDX_W-1:0]   idx_q;
	logic               done_q;
	logic               ok_q;
	logic [POS_W-1:0]   fidx_q;
	logic [CNT_W-1:0]   count_q;

	logic               rd_ok;
	logic               flush;
	logic [SUM_W-1:0]   rd_sum;
	logic [IDX_W-1:0]   rd_idx;
	logic               match;
	logic               place;
	logic               emit;
	byte_t              emit_data;
	byte_t              carry_d;
	logic               ins_d;
	logic               hit_d;
	logic [IDX_W-1:0]   idx_d;
	logic [CNT_W-1:0]   fill_d;
	logic               reject;

	// list is tail-aligned: head reads DEPTH-n empty cells before element 0
	always_comb begin
		rd_ok  = (state_q == ST_RUN) && (step_q < CNT_W'(DEPTH)) &&
			((SUM_W'(step_q) + SUM_W'(n_q)) >= SUM_W'(DEPTH));
		flush  = (state_q == ST_RUN) && (step_q == CNT_W'(DEPTH));
		rd_sum = SUM_W'(step_q) + SUM_W'(n_q) - SUM_W'(DEPTH);
		rd_idx = rd_sum[IDX_W-1:0];
		match  = (head == val_q);
		place  = ((cmd_q == CMD_INS_ASC) && !(val_q > head)) ||
			((cmd_q == CMD_INS_DESC) && !(val_q < head));

		emit      = 1'b0;
		emit_data = head;
		carry_d   = carry_q;
		ins_d     = ins_q;
		hit_d     = hit_q;
		idx_d     = idx_q;

		case (cmd_q)
			CMD_APPEND, CMD_INS_ASC, CMD_INS_DESC: begin
				// after the insertion point everything runs one element late via carry
				if (rd_ok) begin
					emit = 1'b1;
					if (ins_q) begin
						emit_data = carry_q;
						carry_d   = head;
					end else if (place) begin
						emit_data = val_q;
						carry_d   = head;
						ins_d     = 1'b1;
					end
				end else if (flush) begin
					emit      = 1'b1;
					emit_data = ins_q ? carry_q : val_q;
				end
			end
			CMD_SEARCH: begin
				if (rd_ok) begin
					emit = 1'b1;
					if (match && !hit_q) begin
						hit_d = 1'b1;
						idx_d = rd_idx;
					end
				end
			end
			CMD_REM_FIRST: begin
				if (rd_ok) begin
					if (match && !hit_q) begin
						hit_d = 1'b1;
					end else begin
						emit = 1'b1;
					end
				end
			end
			CMD_REM_ALL: begin
				if (rd_ok) begin
					if (match) begin
						hit_d = 1'b1;
					end else begin
						emit = 1'b1;
					end
				end
			end
			CMD_REM_AT: begin
				if (rd_ok) begin
					emit = (EXT_W'(rd_idx) != EXT_W'(pos_q));
				end
			end
			default: begin
			end
		endcase

		fill_d = fill_q + CNT_W'(emit);

		// requests that fail without touching the list
		reject = 1'b0;
		if (!(command inside {CMD_APPEND, CMD_INS_ASC, CMD_INS_DESC, CMD_SEARCH,
				CMD_REM_FIRST, CMD_REM_ALL, CMD_REM_AT})) begin
			reject = 1'b1;
		end else if ((command inside {CMD_APPEND, CMD_INS_ASC, CMD_INS_DESC}) &&
				(n_q == CNT_W'(DEPTH))) begin
			reject = 1'b1;
		end else if ((command == CMD_REM_AT) && (EXT_W'(position) >= EXT_W'(n_q))) begin
			reject = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= CMD_APPEND;
			val_q   <= '0;
			pos_q   <= '0;
			n_q     <= '0;
			step_q  <= '0;
			fill_q  <= '0;
			carry_q <= '0;
			ins_q   <= 1'b0;
			hit_q   <= 1'b0;
			idx_q   <= '0;
			done_q  <= 1'b0;
			ok_q    <= 1'b0;
			fidx_q  <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					done_q <= start && reject;
					if (start) begin
						cmd_q <= command;
						val_q <= value;
						pos_q <= position;
						if (reject) begin
							ok_q    <= 1'b0;
							fidx_q  <= '0;
							count_q <= n_q;
						end else begin
							state_q <= ST_RUN;
							step_q  <= '0;
							fill_q  <= '0;
							ins_q   <= 1'b0;
							hit_q   <= 1'b0;
							idx_q   <= '0;
						end
					end
				end
				ST_RUN: begin
					done_q  <= flush;
					step_q  <= step_q + CNT_W'(1);
					fill_q  <= fill_d;
					carry_q <= carry_d;
					ins_q   <= ins_d;
					hit_q   <= hit_d;
					idx_q   <= idx_d;
					if (flush) begin
						state_q <= ST_IDLE;
						n_q     <= fill_d;
						count_q <= fill_d;
						fidx_q  <= POS_W'(idx_d);
						ok_q    <= (cmd_q inside {CMD_APPEND, CMD_INS_ASC, CMD_INS_DESC,
							CMD_REM_AT}) ? 1'b1 : hit_d;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q == ST_RUN);
	assign done        = done_q;
	assign ok          = ok_q;
	assign found_index = fidx_q;
	assign count       = count_q;
	assign chain.run   = (state_q == ST_RUN);
	assign chain.wr    = emit;
	assign chain.step  = step_q;
	assign chain.fill  = fill_q;
	assign tail        = emit_data;

endmodule

// ===== src/bale_checker.sv =====
// Port-level checks of the byte list engine, bound to the top level
`include "byte_array_list_engine_defines.svh"

module bale_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic                        done,
	input  logic                        ok,
	input  logic [bale_pkg::POS_W-1:0]  found_index,
	input  logic [bale_pkg::CNT_W-1:0]  count
);
	import bale_pkg::*;

	`BALE_ASSERT_NEVER(a_count_range, clk, arst_n, done && (count > CNT_W'(DEPTH)), "count beyond depth")
	`BALE_ASSERT_IMPLY(a_index_ok, clk, arst_n, done && (found_index != '0), ok, "index without match")
	`BALE_ASSERT_NEXT(a_accept_moves, clk, arst_n, start && !busy, busy || done, "request dropped")
	`BALE_ASSERT_IMPLY(a_end_result, clk, arst_n, $fell(busy), done, "pass ended without result")

endmodule

bind byte_array_list_engine bale_checker u_chk (.*);

// ===== test/tb.sv =====
// Self-checking testbench for the byte list engine: directed and random command requests
`timescale 1ns / 1ps

module tb;
	import bale_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIX} mix_mode_t;

	typedef struct packed {
		logic             ok;
		logic [POS_W-1:0] idx;
		logic [CNT_W-1:0] cnt;
	} outcome_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [CMD_W-1:0] command = '0;
	byte_t            value = '0;
	logic [POS_W-1:0] position = '0;
	logic             busy;
	logic             done;
	logic             ok;
	logic [POS_W-1:0] found_index;
	logic [CNT_W-1:0] count;

	// list mirror, advanced as requests are queued
	byte_t    mirror[$];

	outcome_t expected_results[$];
	int       n_errors = 0;
	int       n_cycles = 0;
	bit       gaps_on = 1'b1;

	byte_array_list_engine u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.value       (value),
		.position    (position),
		.done        (done),
		.ok          (ok),
		.found_index (found_index),
		.count       (count)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string what);
		n_errors++;
		$display("mismatch at cycle %0d: %s", n_cycles, what);
	endtask

	function automatic byte_t rand_byte();
		return byte_t'($urandom_range(255));
	endfunction

	function automatic logic [POS_W-1:0] rand_pos();
		return POS_W'($urandom_range(63));
	endfunction

	// half the time a value that is in the list
	function automatic byte_t pick_value();
		byte_t v;
		v = rand_byte();
		if ((mirror.size() != 0) && ($urandom_range(1) == 1)) begin
			v = mirror[$urandom_range(mirror.size() - 1)];
		end
		return v;
	endfunction

	function automatic logic [POS_W-1:0] pick_pos();
		logic [POS_W-1:0] p;
		p = rand_pos();
		if ((mirror.size() != 0) && ($urandom_range(3) != 0)) begin
			p = POS_W'($urandom_range(mirror.size() - 1));
		end
		return p;
	endfunction

	function automatic byte_t dup_value();
		byte_t v;
		case ($urandom_range(4))
			0: v = byte_t'(-1);
			1: v = byte_t'(0);
			2: v = byte_t'(1);
			3: v = byte_t'(-128);
			default: v = byte_t'(127);
		endcase
		return v;
	endfunction

	function automatic logic [CMD_W-1:0] rand_insert_cmd();
		logic [CMD_W-1:0] c;
		case ($urandom_range(2))
			0: c = CMD_APPEND;
			1: c = CMD_INS_ASC;
			default: c = CMD_INS_DESC;
		endcase
		return c;
	endfunction

	function automatic logic [CMD_W-1:0] random_cmd(input mix_mode_t mode);
		logic [CMD_W-1:0] c;
		int               roll;
		roll = int'($urandom_range(99));
		case (mode)
			MODE_GROW: begin
				c = (roll < 85) ? rand_insert_cmd() : CMD_SEARCH;
			end
			MODE_SHRINK: begin
				if (roll < 30) begin
					c = CMD_REM_FIRST;
				end else if (roll < 50) begin
					c = CMD_REM_ALL;
				end else if (roll < 85) begin
					c = CMD_REM_AT;
				end else begin
					c = CMD_SEARCH;
				end
			end
			default: begin
				c = CMD_W'($urandom_range(7));
			end
		endcase
		return c;
	endfunction

	// applies one request to the mirror and gives the result it must produce
	function automatic outcome_t predict(input logic [CMD_W-1:0] cmd, input byte_t val,
			input logic [POS_W-1:0] pos);
		outcome_t o;
		byte_t    keep[$];
		int       at;
		int       i;
		o  = '0;
		at = -1;
		case (cmd)
			CMD_APPEND, CMD_INS_ASC, CMD_INS_DESC: begin
				if (mirror.size() < DEPTH) begin
					at = 0;
					if (cmd == CMD_APPEND) begin
						at = mirror.size();
					end else if (cmd == CMD_INS_ASC) begin
						while ((at < mirror.size()) && (val > mirror[at])) begin
							at++;
						end
					end else begin
						while ((at < mirror.size()) && (val < mirror[at])) begin
							at++;
						end
					end
					mirror.insert(at, val);
					o.ok = 1'b1;
				end
			end
			CMD_SEARCH, CMD_REM_FIRST: begin
				for (i = 0; i < mirror.size(); i++) begin
					if ((at < 0) && (mirror[i] == val)) begin
						at = i;
					end
				end
				if (at >= 0) begin
					o.ok = 1'b1;
					if (cmd == CMD_SEARCH) begin
						o.idx = POS_W'(at);
					end else begin
						mirror.delete(at);
					end
				end
			end
			CMD_REM_ALL: begin
				for (i = 0; i < mirror.size(); i++) begin
					if (mirror[i] == val) begin
						o.ok = 1'b1;
					end else begin
						keep.push_back(mirror[i]);
					end
				end
				mirror = keep;
			end
			CMD_REM_AT: begin
				if (int'(pos) < mirror.size()) begin
					mirror.delete(int'(pos));
					o.ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
		o.cnt = CNT_W'(mirror.size());
		return o;
	endfunction

	// start stays high until the request is taken; the next call may follow at once
	task automatic send_req(input logic [CMD_W-1:0] cmd, input byte_t val,
			input logic [POS_W-1:0] pos);
		outcome_t want;
		want = predict(cmd, val, pos);
		while (gaps_on && ($urandom_range(99) < 7)) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		command  <= cmd;
		value    <= val;
		position <= pos;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		expected_results.push_back(want);
	endtask

	task automatic quiesce();
		start <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic clear_list();
		while (mirror.size() != 0) begin
			send_req(CMD_REM_AT, rand_byte(), POS_W'($urandom_range(mirror.size() - 1)));
		end
	endtask

	task automatic test_empty_list();
		send_req(CMD_SEARCH, byte_t'(5), rand_pos());
		send_req(CMD_REM_FIRST, byte_t'(-1), rand_pos());
		send_req(CMD_REM_ALL, byte_t'(0), rand_pos());
		send_req(CMD_REM_AT, rand_byte(), '0);
		send_req(CMD_UNUSED, rand_byte(), rand_pos());
		quiesce();
	endtask

	task automatic test_fill_and_overflow();
		int i;
		for (i = 0; i < DEPTH; i++) begin
			send_req(CMD_APPEND, byte_t'(i * 4 - 128), rand_pos());
		end
		send_req(CMD_APPEND, byte_t'(1), rand_pos());
		send_req(CMD_INS_ASC, byte_t'(-128), rand_pos());
		send_req(CMD_INS_DESC, rand_byte(), rand_pos());
		send_req(CMD_UNUSED, rand_byte(), rand_pos());
		send_req(CMD_SEARCH, byte_t'(124), rand_pos());
		send_req(CMD_SEARCH, byte_t'(-128), rand_pos());
		send_req(CMD_REM_AT, rand_byte(), POS_W'(DEPTH - 1));
		send_req(CMD_REM_AT, rand_byte(), POS_W'(DEPTH - 1));
		send_req(CMD_SEARCH, byte_t'(124), rand_pos());
		clear_list();
		quiesce();
	endtask

	task automatic test_ascending_insert();
		int i;
		send_req(CMD_INS_ASC, byte_t'(127), rand_pos());
		send_req(CMD_INS_ASC, byte_t'(-128), rand_pos());
		send_req(CMD_INS_ASC, byte_t'(0), rand_pos());
		for (i = 0; i < 40; i++) begin
			send_req(CMD_INS_ASC, rand_byte(), rand_pos());
		end
		for (i = 0; i < 12; i++) begin
			send_req(CMD_SEARCH, pick_value(), rand_pos());
		end
		for (i = 0; i < 12; i++) begin
			send_req(CMD_REM_FIRST, pick_value(), rand_pos());
		end
		clear_list();
		quiesce();
	endtask

	task automatic test_descending_insert();
		int i;
		send_req(CMD_INS_DESC, byte_t'(-128), rand_pos());
		send_req(CMD_INS_DESC, byte_t'(127), rand_pos());
		send_req(CMD_INS_DESC, byte_t'(-1), rand_pos());
		for (i = 0; i < 40; i++) begin
			send_req(CMD_INS_DESC, rand_byte(), rand_pos());
		end
		for (i = 0; i < 12; i++) begin
			send_req(CMD_SEARCH, pick_value(), rand_pos());
		end
		for (i = 0; i < 12; i++) begin
			send_req(CMD_REM_FIRST, pick_value(), rand_pos());
		end
		clear_list();
		quiesce();
	endtask

	task automatic test_duplicates();
		int i;
		for (i = 0; i < 48; i++) begin
			send_req(rand_insert_cmd(), dup_value(), rand_pos());
		end
		for (i = 0; i < 5; i++) begin
			send_req(CMD_SEARCH, dup_value(), rand_pos());
		end
		for (i = 0; i < 5; i++) begin
			send_req(CMD_REM_FIRST, dup_value(), rand_pos());
		end
		send_req(CMD_REM_ALL, byte_t'(-1), rand_pos());
		send_req(CMD_REM_ALL, byte_t'(0), rand_pos());
		send_req(CMD_REM_ALL, byte_t'(1), rand_pos());
		send_req(CMD_REM_ALL, byte_t'(-128), rand_pos());
		send_req(CMD_REM_ALL, byte_t'(127), rand_pos());
		send_req(CMD_REM_ALL, byte_t'(0), rand_pos());
		send_req(CMD_SEARCH, byte_t'(127), rand_pos());
		clear_list();
		quiesce();
	endtask

	task automatic test_random_mix();
		int        i;
		mix_mode_t mode;
		for (i = 0; i < 480; i++) begin
			if (i < 120) begin
				mode = MODE_GROW;
			end else if (i < 220) begin
				mode = MODE_SHRINK;
			end else begin
				mode = MODE_MIX;
			end
			// a long stretch with no idle cycles between requests
			gaps_on = (i < 250) || (i >= 400);
			send_req(random_cmd(mode), pick_value(), pick_pos());
		end
		gaps_on = 1'b1;
		clear_list();
		quiesce();
	endtask

	always @(posedge clk) begin : p_check
		outcome_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want = expected_results.pop_front();
				if ({ok, found_index, count} !== want) begin
					report_mismatch($sformatf(
						"got ok %0b index %0d count %0d, expected ok %0b index %0d count %0d",
						ok, found_index, count, want.ok, want.idx, want.cnt));
				end
			end
		end
	end

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles == CYCLE_LIMIT) begin
			report_mismatch("cycle limit reached");
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_fill_and_overflow();
		test_ascending_insert();
		test_descending_insert();
		test_duplicates();
		test_random_mix();
		if (n_errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
